>>> rtl/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants and types for the ray versus box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

  // Coordinate format: signed fixed point, Q16.16.
  localparam int CoordBits = 32;
  localparam int FracBits  = 16;

  // Divider layout: one quotient bit per step, several steps per stage.
  localparam int QuotBits      = CoordBits;
  localparam int StepsPerStage = 4;
  localparam int DivStages     = QuotBits / StepsPerStage;
  // Prep register plus the divider stages.
  localparam int DivLat        = DivStages + 1;
  // Divider, axis output register, xy merge, z test.
  localparam int PipeLat       = DivLat + 3;

  typedef logic signed [CoordBits-1:0] coord_t;

  // State of one restoring divider between stages.
  typedef struct packed {
    logic                 neg;   // quotient sign
    logic                 ovf;   // quotient does not fit QuotBits
    logic [CoordBits-1:0] dmag;  // divisor magnitude
    logic [CoordBits:0]   rem;   // partial remainder
    logic [CoordBits-1:0] nlow;  // dividend bits still to shift in
    logic [QuotBits-1:0]  quot;  // quotient bits so far
  } div_stage_t;

  // Per-axis flags carried alongside the dividers.
  typedef struct packed {
    logic dzero;   // direction component is zero
    logic inslab;  // origin lies within the slab
  } axis_flag_t;

  // Saturation limits of the coordinate range.
  localparam coord_t CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

endpackage

>>> rtl/rbst_div.sv
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined fixed-point divider: (bound - org) / dir, truncated, saturated.
// ----------------------------------------------------------------------------
module rbst_div (
  input  logic            clk_i,
  input  logic            en_i,
  input  rbst_pkg::coord_t bound_i,
  input  rbst_pkg::coord_t org_i,
  input  rbst_pkg::coord_t dir_i,
  output rbst_pkg::coord_t quot_o
);
  import rbst_pkg::*;

  logic signed [CoordBits:0] diff;
  logic [CoordBits:0]        nmag;
  logic [CoordBits-1:0]      dmag;
  div_stage_t                prep_d;
  div_stage_t                stage_q [DivLat];
  logic [QuotBits:0]         qmag;
  logic [QuotBits:0]         neg_lim;

  // Exact difference, its magnitude and the overflow check of the quotient.
  always_comb begin
    diff   = {bound_i[CoordBits-1], bound_i} - {org_i[CoordBits-1], org_i};
    nmag   = diff[CoordBits] ? -diff : diff;
    dmag   = dir_i[CoordBits-1] ? -dir_i : dir_i;
    prep_d.neg  = diff[CoordBits] ^ dir_i[CoordBits-1];
    prep_d.ovf  = {{(FracBits){1'b0}}, nmag} >= {1'b0, dmag, {FracBits{1'b0}}};
    prep_d.dmag = dmag;
    prep_d.rem  = {{(FracBits){1'b0}}, nmag[CoordBits:FracBits]};
    prep_d.nlow = {nmag[FracBits-1:0], {(CoordBits-FracBits){1'b0}}};
    prep_d.quot = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= prep_d;
    end
  end

  // Restoring division, a few quotient bits per stage.
  for (genvar s = 1; s < DivLat; s++) begin : g_stage
    div_stage_t st_d;
    always_comb begin
      st_d = stage_q[s-1];
      for (int k = 0; k < StepsPerStage; k++) begin
        st_d.rem  = {st_d.rem[CoordBits-1:0], st_d.nlow[CoordBits-1]};
        st_d.nlow = {st_d.nlow[CoordBits-2:0], 1'b0};
        if (st_d.rem >= {1'b0, st_d.dmag}) begin
          st_d.rem  = st_d.rem - {1'b0, st_d.dmag};
          st_d.quot = {st_d.quot[QuotBits-2:0], 1'b1};
        end else begin
          st_d.quot = {st_d.quot[QuotBits-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[s] <= st_d;
      end
    end
  end

  // Saturate to the signed range and apply the sign.
  always_comb begin
    neg_lim = {1'b0, CoordMin};
    qmag    = {1'b0, stage_q[DivLat-1].quot};
    if (stage_q[DivLat-1].neg) begin
      if (stage_q[DivLat-1].ovf || qmag > neg_lim) begin
        quot_o = CoordMin;
      end else begin
        quot_o = coord_t'(-qmag[CoordBits-1:0]);
      end
    end else begin
      if (stage_q[DivLat-1].ovf || qmag[CoordBits-1]) begin
        quot_o = CoordMax;
      end else begin
        quot_o = coord_t'(qmag[CoordBits-1:0]);
      end
    end
  end

endmodule

>>> rtl/rbst_axis.sv
// ----------------------------------------------------------------------------
// rbst_axis
// Entry and exit distance of one axis slab, with the zero direction case.
// ----------------------------------------------------------------------------
module rbst_axis (
  input  logic             clk_i,
  input  logic             en_i,
  input  rbst_pkg::coord_t org_i,
  input  rbst_pkg::coord_t dir_i,
  input  rbst_pkg::coord_t lo_i,
  input  rbst_pkg::coord_t hi_i,
  output rbst_pkg::coord_t tmin_o,
  output rbst_pkg::coord_t tmax_o,
  output logic             ok_o
);
  import rbst_pkg::*;

  coord_t     ta, tb;
  axis_flag_t flag_q [DivLat];
  axis_flag_t flag_d;
  coord_t     tmin_q, tmax_q;
  logic       ok_q;

  rbst_div u_div_lo (
    .clk_i, .en_i,
    .bound_i(lo_i), .org_i, .dir_i, .quot_o(ta)
  );
  rbst_div u_div_hi (
    .clk_i, .en_i,
    .bound_i(hi_i), .org_i, .dir_i, .quot_o(tb)
  );

  // Zero direction flags travel beside the divider stages.
  always_comb begin
    flag_d.dzero  = (dir_i == '0);
    flag_d.inslab = (org_i >= lo_i) && (org_i <= hi_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flag_q[0] <= flag_d;
      for (int i = 1; i < DivLat; i++) begin
        flag_q[i] <= flag_q[i-1];
      end
    end
  end

  // Order the two distances; an unbounded interval for a zero direction.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (flag_q[DivLat-1].dzero) begin
        tmin_q <= CoordMin;
        tmax_q <= CoordMax;
        ok_q   <= flag_q[DivLat-1].inslab;
      end else begin
        tmin_q <= (tb < ta) ? tb : ta;
        tmax_q <= (ta < tb) ? tb : ta;
        ok_q   <= 1'b1;
      end
    end
  end

  assign tmin_o = tmin_q;
  assign tmax_o = tmax_q;
  assign ok_o   = ok_q;

endmodule

>>> rtl/ray_box_slab_test.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray versus axis-aligned box slab test on signed Q16.16 coordinates.
//
//   channel | valid       | stall       | word
//   --------+-------------+-------------+-------------------------------------
//   in      | in_valid_i  | in_stall_o  | origin, dir, lo, hi (x, y, z)
//   out     | out_valid_o | out_stall_i | hit_o
//
// One word can enter per cycle while the input is not stalled; each result
// passes through the divider input register, eight divider stages of four
// quotient bits each, the ordered axis interval, the x and y merge and the z
// test. Reset clears only the valid bits of the pipeline.
// A stalled waiting result freezes the whole pipeline and stalls the input in
// the same cycle; bubbles inside the pipeline are not squeezed out.
// ----------------------------------------------------------------------------
module ray_box_slab_test (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rbst_pkg::coord_t origin_x_i,
  input  rbst_pkg::coord_t origin_y_i,
  input  rbst_pkg::coord_t origin_z_i,
  input  rbst_pkg::coord_t dir_x_i,
  input  rbst_pkg::coord_t dir_y_i,
  input  rbst_pkg::coord_t dir_z_i,
  input  rbst_pkg::coord_t lo_x_i,
  input  rbst_pkg::coord_t lo_y_i,
  input  rbst_pkg::coord_t lo_z_i,
  input  rbst_pkg::coord_t hi_x_i,
  input  rbst_pkg::coord_t hi_y_i,
  input  rbst_pkg::coord_t hi_z_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             hit_o
);
  import rbst_pkg::*;

  logic               en;
  logic [PipeLat-1:0] vld_q;
  coord_t             xmin, xmax, ymin, ymax, zmin, zmax;
  logic               xok, yok, zok;
  coord_t             mmin_q, mmax_q, zmin_q, zmax_q;
  logic               mok_q, zok_q, hit_q;

  // The pipeline moves unless a finished word is held by the sink.
  assign en         = !(vld_q[PipeLat-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeLat-2:0], in_valid_i};
    end
  end

  rbst_axis u_axis_x (
    .clk_i, .en_i(en),
    .org_i(origin_x_i), .dir_i(dir_x_i), .lo_i(lo_x_i), .hi_i(hi_x_i),
    .tmin_o(xmin), .tmax_o(xmax), .ok_o(xok)
  );
  rbst_axis u_axis_y (
    .clk_i, .en_i(en),
    .org_i(origin_y_i), .dir_i(dir_y_i), .lo_i(lo_y_i), .hi_i(hi_y_i),
    .tmin_o(ymin), .tmax_o(ymax), .ok_o(yok)
  );
  rbst_axis u_axis_z (
    .clk_i, .en_i(en),
    .org_i(origin_z_i), .dir_i(dir_z_i), .lo_i(lo_z_i), .hi_i(hi_z_i),
    .tmin_o(zmin), .tmax_o(zmax), .ok_o(zok)
  );

  // Test x against y and merge the two intervals.
  always_ff @(posedge clk_i) begin
    if (en) begin
      mok_q  <= xok && yok && !(ymax < xmin) && !(xmax < ymin);
      mmin_q <= (xmin < ymin) ? ymin : xmin;
      mmax_q <= (ymax < xmax) ? ymax : xmax;
      zmin_q <= zmin;
      zmax_q <= zmax;
      zok_q  <= zok;
    end
  end

  // Test the merged interval against z.
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= mok_q && zok_q && !(zmax_q < mmin_q) && !(mmax_q < zmin_q);
    end
  end

  assign out_valid_o = vld_q[PipeLat-1];
  assign hit_o       = hit_q;

  // Back pressure only when a result is waiting and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // A word one stage from the end arrives at the output on a free edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[PipeLat-2] && en) |=> out_valid_o)
    else $error("word lost before the output stage");

  // A stall freezes every valid bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved under stall");

endmodule
